/* hdl/png_scanline_unfilter_macros.svh */
// ----------------------------------------------------------------------------
// png_scanline_unfilter_macros
// Assertion macros shared by the scanline unfilter modules.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PUS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PUS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/pus_pkg.sv */
// ----------------------------------------------------------------------------
// pus_pkg
// Shared types, widths and register codes of the scanline unfilter.
// ----------------------------------------------------------------------------
package pus_pkg;

  // line store geometry
  localparam int MAX_ROW_BYTES = 4096;
  localparam int ADDR_W        = $clog2(MAX_ROW_BYTES);
  localparam int POS_W         = ADDR_W + 1;
  localparam int ROWS_W        = 16;
  localparam int BPP_W         = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPP       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd2;

  // filter type codes as they appear in the stream
  localparam logic [7:0] CODE_NONE  = 8'd0;
  localparam logic [7:0] CODE_SUB   = 8'd1;
  localparam logic [7:0] CODE_UP    = 8'd2;
  localparam logic [7:0] CODE_AVG   = 8'd3;
  localparam logic [7:0] CODE_PAETH = 8'd4;

  // decoded filter of a row, raw copy for unknown codes
  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH,
    FILT_RAW
  } filt_t;

  // one data byte on its way from the sequencer to the reconstruction stage
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    filt_t             filt;
    logic              first_row;
    logic              has_left;
    logic              row_end;
    logic              image_end;
  } item_t;

  function automatic filt_t filt_decode(input logic [7:0] code);
    filt_t f;
    unique case (code)
      CODE_NONE:  f = FILT_NONE;
      CODE_SUB:   f = FILT_SUB;
      CODE_UP:    f = FILT_UP;
      CODE_AVG:   f = FILT_AVG;
      CODE_PAETH: f = FILT_PAETH;
      default:    f = FILT_RAW;
    endcase
    return f;
  endfunction

endpackage

/* hdl/pus_seq.sv */
// ----------------------------------------------------------------------------
// pus_seq
// Input sequencer: tracks byte position, row count and row filter, tags each
// data byte with its line store address and row/image end flags.
// ----------------------------------------------------------------------------
module pus_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   stream_byte,
  input  logic [pus_pkg::POS_W-1:0]    rb_eff,
  input  logic [pus_pkg::BPP_W-1:0]    bpp_eff,
  input  logic [pus_pkg::ROWS_W-1:0]   rows_eff,
  input  logic                         data_ready,
  output logic                         data_fire,
  output pus_pkg::item_t               item
);

  logic [pus_pkg::POS_W-1:0]  byte_position;
  logic [pus_pkg::ROWS_W-1:0] row_index;
  pus_pkg::filt_t             row_filter;

  logic                       at_filter;
  logic                       in_fire;
  logic                       row_done;
  logic [pus_pkg::ROWS_W-1:0] row_index_inc;
  logic                       img_done;
  logic [pus_pkg::ADDR_W-1:0] addr;

  // filter bytes need no downstream room
  assign at_filter = (byte_position == '0);
  assign in_ready  = at_filter || data_ready;
  assign in_fire   = in_valid && in_ready;
  assign data_fire = in_fire && !at_filter;

  // row and image end detection
  assign addr          = pus_pkg::ADDR_W'(byte_position - pus_pkg::POS_W'(1));
  assign row_done      = (byte_position >= rb_eff);
  assign row_index_inc = row_index + pus_pkg::ROWS_W'(1);
  assign img_done      = row_done && ((row_index_inc >= rows_eff) || (row_index_inc == '0));

  // tag the data byte
  always_comb begin
    item.addr      = addr;
    item.data      = stream_byte;
    item.filt      = row_filter;
    item.first_row = (row_index == '0);
    item.has_left  = (addr >= pus_pkg::ADDR_W'(bpp_eff));
    item.row_end   = row_done;
    item.image_end = img_done;
  end

  // position, row and filter tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      row_index     <= '0;
      row_filter    <= pus_pkg::FILT_NONE;
    end else if (in_fire) begin
      if (at_filter) begin
        row_filter    <= pus_pkg::filt_decode(stream_byte);
        byte_position <= pus_pkg::POS_W'(1);
      end else if (row_done) begin
        byte_position <= '0;
        row_index     <= img_done ? '0 : row_index_inc;
      end else begin
        byte_position <= byte_position + pus_pkg::POS_W'(1);
      end
    end
  end

endmodule

/* hdl/pus_recon.sv */
// ----------------------------------------------------------------------------
// pus_recon
// Reconstruction stage: previous-row line store, left/above history,
// filter arithmetic and the output register.
// ----------------------------------------------------------------------------
`include "png_scanline_unfilter_macros.svh"

module pus_recon (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       data_fire,
  output logic                       data_ready,
  input  pus_pkg::item_t             item,
  input  logic [pus_pkg::BPP_W-1:0]  bpp_eff,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 pixel_byte,
  output logic                       row_end,
  output logic                       image_end,
  output logic                       bad_filter
);

  logic [7:0] line_mem [pus_pkg::MAX_ROW_BYTES];

  logic           s1_valid;
  pus_pkg::item_t s1;
  logic [7:0]     s1_above;
  logic           s1_adv;

  logic [31:0] left_hist;
  logic [31:0] above_hist;

  logic [1:0] sel;
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [7:0] pa;
  logic [7:0] pb;
  logic [8:0] ab_sum;
  logic [8:0] c_dbl;
  logic [8:0] pc;
  logic [7:0] pred;
  logic [7:0] avg;
  logic [7:0] v;

  // stage handshake
  assign s1_adv     = s1_valid && (!out_valid || out_ready);
  assign data_ready = !s1_valid || s1_adv;

  // line store: read on transfer in, write back when the stage moves on
  // a read of the entry being written in the same cycle takes the new byte
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1.addr] <= v;
    end
    if (data_fire) begin
      if (s1_adv && (item.addr == s1.addr)) begin
        s1_above <= v;
      end else begin
        s1_above <= line_mem[item.addr];
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire) begin
      s1 <= item;
    end
  end

  // neighbor bytes
  assign sel = 2'(bpp_eff - pus_pkg::BPP_W'(1));
  assign a   = s1.has_left ? left_hist[8*sel +: 8] : 8'd0;
  assign b   = s1.first_row ? 8'd0 : s1_above;
  assign c   = (s1.has_left && !s1.first_row) ? above_hist[8*sel +: 8] : 8'd0;

  // paeth predictor
  assign pa     = (b >= c) ? (b - c) : (c - b);
  assign pb     = (a >= c) ? (a - c) : (c - a);
  assign ab_sum = {1'b0, a} + {1'b0, b};
  assign c_dbl  = {c, 1'b0};
  assign pc     = (ab_sum >= c_dbl) ? (ab_sum - c_dbl) : (c_dbl - ab_sum);

  always_comb begin
    if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
      pred = a;
    end else if ({1'b0, pb} <= pc) begin
      pred = b;
    end else begin
      pred = c;
    end
  end

  assign avg = ab_sum[8:1];

  // filter select
  always_comb begin
    case (s1.filt)
      pus_pkg::FILT_SUB:   v = s1.data + a;
      pus_pkg::FILT_UP:    v = s1.data + b;
      pus_pkg::FILT_AVG:   v = s1.data + avg;
      pus_pkg::FILT_PAETH: v = s1.data + pred;
      default:             v = s1.data;
    endcase
  end

  // left and above history, newest byte low
  always_ff @(posedge clk) begin
    if (rst) begin
      left_hist  <= '0;
      above_hist <= '0;
    end else if (s1_adv) begin
      left_hist  <= {left_hist[23:0], v};
      above_hist <= {above_hist[23:0], b};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pixel_byte <= v;
      row_end    <= s1.row_end;
      image_end  <= s1.image_end;
      bad_filter <= (s1.filt == pus_pkg::FILT_RAW);
    end
  end

  // checks
  `PUS_ASSERT_NOW(a_no_overrun, data_fire && s1_valid, s1_adv, "stage overwritten while held")
  `PUS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_byte), "output changed while held")
  `PUS_ASSERT_NEXT(a_hold, s1_valid && !s1_adv, s1_valid && $stable(s1), "stalled item lost")
  `PUS_ASSERT_NOW(a_img_row, out_valid && image_end, row_end, "image end without row end")

endmodule

/* hdl/png_scanline_unfilter.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth).
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries the inflated stream, one byte per
// transfer: a filter type byte at the start of each row, then row_bytes data
// bytes. Filter bytes give no output; each data byte gives one output
// transfer on out_valid/out_ready with the rebuilt byte and row_end,
// image_end and bad_filter flags (unknown filter codes copy the row raw).
// A data byte passes the reconstruction stage register and then the output
// register before out_valid rises. Throughput is one byte per cycle while
// the receiver keeps up: the line store is read at the input transfer and
// written back when the byte leaves the reconstruction stage; a read of the
// entry being written in that cycle takes the new byte directly.
// When the receiver stalls, one result waits in the output register and one
// more in the reconstruction stage, then in_ready drops for data bytes.
// Reset (rst, synchronous) empties the pipeline, expects a filter byte and
// loads row_bytes 4096, pixel size 4, image_rows 1. The line store needs no
// clearing: the first row reads zero above, and later rows read only what
// the row before wrote.
// Configuration writes via cfg_write/cfg_index/cfg_data apply at once and
// belong between bytes while no result is pending.
// ----------------------------------------------------------------------------
module png_scanline_unfilter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pus_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pus_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        stream_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        pixel_byte,
  output logic                              row_end,
  output logic                              image_end,
  output logic                              bad_filter
);

  logic [12:0]                       row_bytes;
  logic [pus_pkg::BPP_W-1:0]         pixel_bytes;
  logic [pus_pkg::ROWS_W-1:0]        image_rows;

  logic [pus_pkg::POS_W-1:0]         rb_eff;
  logic [pus_pkg::BPP_W-1:0]         bpp_eff;
  logic [pus_pkg::ROWS_W-1:0]        rows_eff;

  logic                              data_fire;
  logic                              data_ready;
  pus_pkg::item_t                    item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes   <= 13'(pus_pkg::MAX_ROW_BYTES);
      pixel_bytes <= 3'd4;
      image_rows  <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pus_pkg::REG_ROW_BYTES: row_bytes   <= cfg_data[12:0];
        pus_pkg::REG_BPP:       pixel_bytes <= cfg_data[2:0];
        pus_pkg::REG_ROWS:      image_rows  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp register values to their usable range
  always_comb begin
    if (row_bytes == '0) begin
      rb_eff = pus_pkg::POS_W'(1);
    end else if (row_bytes > 13'(pus_pkg::MAX_ROW_BYTES)) begin
      rb_eff = pus_pkg::POS_W'(pus_pkg::MAX_ROW_BYTES);
    end else begin
      rb_eff = pus_pkg::POS_W'(row_bytes);
    end
    if (pixel_bytes == '0) begin
      bpp_eff = 3'd1;
    end else if (pixel_bytes > 3'd4) begin
      bpp_eff = 3'd4;
    end else begin
      bpp_eff = pixel_bytes;
    end
    rows_eff = (image_rows == '0) ? 16'd1 : image_rows;
  end

  pus_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .rb_eff      (rb_eff),
    .bpp_eff     (bpp_eff),
    .rows_eff    (rows_eff),
    .data_ready  (data_ready),
    .data_fire   (data_fire),
    .item        (item)
  );

  pus_recon u_recon (
    .clk        (clk),
    .rst        (rst),
    .data_fire  (data_fire),
    .data_ready (data_ready),
    .item       (item),
    .bpp_eff    (bpp_eff),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_byte (pixel_byte),
    .row_end    (row_end),
    .image_end  (image_end),
    .bad_filter (bad_filter)
  );

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PNG scanline unfilter.
// ----------------------------------------------------------------------------
// A short directed image walks through every filter type and an unknown
// code. Random images with random row lengths, pixel sizes and row counts
// follow, including out-of-range register values, one-byte rows, a row
// count change in the middle of an image and a row length cut in the
// middle of a row. Every accepted stream byte goes through an in-bench
// model of the reconstruction, and every output transfer is compared field
// by field with the oldest predicted byte. Both channels stall at random in
// the first two groups, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int HOLD_AT  = 300;
  localparam int HOLD_LEN = 400;

  // a filter code outside the known set
  localparam logic [7:0] BAD_CODE = 8'd5;

  // rebuilt byte with its flags, as seen on the output channel
  typedef struct {
    logic [7:0] pixel;
    logic       last_in_row;
    logic       last_in_image;
    logic       raw_copy;
  } recon_t;

  logic                           clk;
  logic                           rst         = 1'b1;
  logic                           cfg_write   = 1'b0;
  logic [pus_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [pus_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  logic                           in_valid    = 1'b0;
  logic                           in_ready;
  logic [7:0]                     stream_byte = '0;
  logic                           out_valid;
  logic                           out_ready   = 1'b0;
  logic [7:0]                     pixel_byte;
  logic                           row_end;
  logic                           image_end;
  logic                           bad_filter;

  // stimulus and expectation stores
  logic [7:0] pending_stream[$];
  recon_t     expected_pixels[$];

  // model copy of the registers
  logic [12:0] row_len_reg;
  logic [2:0]  pix_size_reg;
  logic [15:0] img_rows_reg;

  // model copy of the block state
  logic [7:0]  prev_row [pus_pkg::MAX_ROW_BYTES];
  logic [31:0] left_hist;
  logic [31:0] above_hist;
  int          byte_pos;
  logic [15:0] row_num;
  logic [7:0]  row_code;

  int send_idle_pct = 8;
  int recv_idle_pct = 48;
  int accepted_inputs = 0;
  int hold_left = 0;
  bit hold_armed = 1'b1;
  int err_count = 0;
  int bytes_checked = 0;
  int rows_checked = 0;
  int images_checked = 0;
  int raw_bytes = 0;
  int config_sets = 0;

  png_scanline_unfilter u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .stream_byte(stream_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_byte (pixel_byte),
    .row_end    (row_end),
    .image_end  (image_end),
    .bad_filter (bad_filter)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int clamp_row_len(input int n);
    if (n == 0) return 1;
    if (n > pus_pkg::MAX_ROW_BYTES) return pus_pkg::MAX_ROW_BYTES;
    return n;
  endfunction

  function automatic int paeth_pick(input int a, input int b, input int c);
    int pa, pb, pc;
    pa = b - c;
    pb = a - c;
    pc = a + b - 2 * c;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // reconstruct one accepted stream byte and queue the expected output
  task automatic unfilter_byte(input logic [7:0] x);
    int     rb, bpp, rows, idx, a, b, c, v;
    bit     top;
    recon_t r;
    rb   = clamp_row_len(int'(row_len_reg));
    bpp  = (pix_size_reg == 0) ? 1 : ((pix_size_reg > 4) ? 4 : int'(pix_size_reg));
    rows = (img_rows_reg == 0) ? 1 : int'(img_rows_reg);
    if (byte_pos == 0) begin
      // filter type byte opens the row
      row_code   = x;
      left_hist  = '0;
      above_hist = '0;
      byte_pos   = 1;
    end else begin
      idx = byte_pos - 1;
      if (idx >= pus_pkg::MAX_ROW_BYTES) idx = pus_pkg::MAX_ROW_BYTES - 1;
      top = (row_num == 0);
      a = (idx >= bpp) ? int'((left_hist >> (8 * (bpp - 1))) & 32'hFF) : 0;
      b = top ? 0 : int'(prev_row[idx]);
      c = (!top && idx >= bpp) ? int'((above_hist >> (8 * (bpp - 1))) & 32'hFF) : 0;
      case (row_code)
        pus_pkg::CODE_NONE:  v = x;
        pus_pkg::CODE_SUB:   v = x + a;
        pus_pkg::CODE_UP:    v = x + b;
        pus_pkg::CODE_AVG:   v = x + ((a + b) >> 1);
        pus_pkg::CODE_PAETH: v = x + paeth_pick(a, b, c);
        default:             v = x;
      endcase
      v = v & 255;
      prev_row[idx] = v[7:0];
      left_hist     = {left_hist[23:0], v[7:0]};
      above_hist    = {above_hist[23:0], b[7:0]};
      r.pixel         = v[7:0];
      r.last_in_row   = (byte_pos >= rb);
      r.last_in_image = 1'b0;
      r.raw_copy      = (row_code > pus_pkg::CODE_PAETH);
      if (r.last_in_row) begin
        byte_pos = 0;
        row_num  = row_num + 16'd1;
        if (int'(row_num) >= rows || row_num == 0) begin
          r.last_in_image = 1'b1;
          row_num = '0;
        end
      end else begin
        byte_pos++;
      end
      expected_pixels.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // compare one output transfer against the oldest prediction
  task automatic check_result();
    recon_t e;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("output byte %02h with nothing pending", pixel_byte));
    end else begin
      e = expected_pixels.pop_front();
      if (pixel_byte !== e.pixel)
        report_mismatch($sformatf("pixel_byte %02h, want %02h", pixel_byte, e.pixel));
      if (row_end !== e.last_in_row)
        report_mismatch($sformatf("row_end %b, want %b", row_end, e.last_in_row));
      if (image_end !== e.last_in_image)
        report_mismatch($sformatf("image_end %b, want %b", image_end, e.last_in_image));
      if (bad_filter !== e.raw_copy)
        report_mismatch($sformatf("bad_filter %b, want %b", bad_filter, e.raw_copy));
      bytes_checked++;
      if (e.last_in_row) rows_checked++;
      if (e.last_in_image) images_checked++;
      if (e.raw_copy) raw_bytes++;
    end
  endtask

  // input driver, fed from the pending stream
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid    <= 1'b1;
        stream_byte <= pending_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, once, after a fixed number of input transfers
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && accepted_inputs == HOLD_AT) begin
      hold_left  <= HOLD_LEN;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: check output transfers, predict from input transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        unfilter_byte(stream_byte);
        accepted_inputs <= accepted_inputs + 1;
      end
    end
  end

  // write all three registers on consecutive edges
  task automatic set_config(input int rb, input int bpp, input int rows);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= pus_pkg::REG_ROW_BYTES;
    cfg_data  <= rb[15:0];
    @(posedge clk);
    cfg_index <= pus_pkg::REG_BPP;
    cfg_data  <= bpp[15:0];
    @(posedge clk);
    cfg_index <= pus_pkg::REG_ROWS;
    cfg_data  <= rows[15:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    row_len_reg  = rb[12:0];
    pix_size_reg = bpp[2:0];
    img_rows_reg = rows[15:0];
    config_sets++;
    @(negedge clk);
  endtask

  // wait until every byte is taken and every result is out
  task automatic wait_drain();
    @(negedge clk);
    while (pending_stream.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_data();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_filter();
    if ($urandom_range(0, 99) < 88) return 8'($urandom_range(0, 4));
    return 8'($urandom_range(5, 255));
  endfunction

  task automatic push_row(input logic [7:0] code, input int n);
    pending_stream.push_back(code);
    for (int k = 0; k < n; k++) pending_stream.push_back(rand_data());
  endtask

  task automatic push_triplet_row(input logic [7:0] code, input logic [7:0] d0,
                                  input logic [7:0] d1, input logic [7:0] d2);
    pending_stream.push_back(code);
    pending_stream.push_back(d0);
    pending_stream.push_back(d1);
    pending_stream.push_back(d2);
  endtask

  task automatic push_image(input int rows, input int rb);
    for (int r = 0; r < rows; r++) push_row(rand_filter(), rb);
  endtask

  // one random setting followed by whole images
  task automatic random_phase(output int pushed);
    int sel, rb, bpp, rows, rb_eff, rows_eff;
    sel = $urandom_range(0, 19);
    if (sel == 0) rb = 0;
    else if (sel == 1) rb = 1;
    else if (sel < 6) rb = $urandom_range(2, 8);
    else rb = $urandom_range(2, 40);
    bpp  = $urandom_range(0, 7);
    rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    set_config(rb, bpp, rows);
    rb_eff   = clamp_row_len(rb);
    rows_eff = (rows == 0) ? 1 : rows;
    pushed = 0;
    while (pushed < 60) begin
      push_image(rows_eff, rb_eff);
      pushed += rows_eff * (rb_eff + 1);
    end
    wait_drain();
  endtask

  initial begin
    int grp, n, pushed;
    left_hist  = '0;
    above_hist = '0;
    byte_pos   = 0;
    row_num    = '0;
    row_code   = '0;
    row_len_reg  = 13'd4096;
    pix_size_reg = 3'd4;
    img_rows_reg = 16'd1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed image: every filter, wrap-around sums, an unknown code
    set_config(3, 1, 6);
    push_triplet_row(pus_pkg::CODE_NONE,  8'h00, 8'hFF, 8'h80);
    push_triplet_row(pus_pkg::CODE_SUB,   8'hFF, 8'hFF, 8'h01);
    push_triplet_row(pus_pkg::CODE_UP,    8'hFF, 8'h01, 8'h00);
    push_triplet_row(pus_pkg::CODE_AVG,   8'hFF, 8'hFF, 8'hFF);
    push_triplet_row(BAD_CODE,            8'h12, 8'h34, 8'hFF);
    push_triplet_row(pus_pkg::CODE_PAETH, 8'h00, 8'h00, 8'hFF);
    wait_drain();

    for (grp = 0; grp < 3; grp++) begin
      if (grp == 0) begin
        send_idle_pct = 8;
        recv_idle_pct = 48;
      end else if (grp == 1) begin
        send_idle_pct = 48;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n = 0;
      while (n < 380) begin
        random_phase(pushed);
        n += pushed;
      end
      if (grp == 1) begin
        // row count lowered below the current row: next row ends the image
        set_config(7, 3, 65535);
        push_image(3, 7);
        wait_drain();
        set_config(7, 3, 2);
        push_image(1, 7);
        wait_drain();
      end
      if (grp == 2) begin
        // row length cut below the current position: next byte ends the row
        set_config(10, 2, 4);
        push_row(rand_filter(), 10);
        push_row(rand_filter(), 6);
        wait_drain();
        set_config(5, 2, 4);
        pending_stream.push_back(rand_data());
        push_image(2, 5);
        wait_drain();
      end
    end

    repeat (8) @(posedge clk);
    $display("covered %0d rebuilt bytes in %0d rows and %0d images, %0d of them raw copies",
             bytes_checked, rows_checked, images_checked, raw_bytes);
    $display("%0d register settings, %0d input transfers, %0d mismatches",
             config_sets, accepted_inputs, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/pus_pkg.sv
hdl/pus_seq.sv
hdl/pus_recon.sv
hdl/png_scanline_unfilter.sv
sim/tb.sv
